/* hw/rtl/tpr_pkg.sv */
// Shared types and constants for the TLB and page-frame replacement block.
package tpr_pkg;

   localparam int TLB_MAX    = 16;
   localparam int FRAMES_MAX = 64;
   localparam int TIDX_W     = $clog2(TLB_MAX);
   localparam int FIDX_W     = $clog2(FRAMES_MAX);
   localparam int TCNT_W     = $clog2(TLB_MAX + 1);
   localparam int FCNT_W     = $clog2(FRAMES_MAX + 1);
   localparam int PAGE_W     = 31;
   localparam int STAMP_W    = 32;
   localparam int CNT_W      = 32;
   localparam int ADDR_W     = 32;
   localparam int PSZ_W      = 17;
   localparam int CSR_IDX_W  = 3;

   // Cycles for an LRU minimum to ripple through the longest cell chain
   localparam int SCAN_LEN   = FRAMES_MAX;
   localparam int SCAN_W     = $clog2(SCAN_LEN + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAGE_SIZE   = 3'd0,
      CSR_TLB_ENTRIES = 3'd1,
      CSR_FRAMES      = 3'd2,
      CSR_PAGE_POLICY = 3'd3,
      CSR_TLB_POLICY  = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOOK,
      ST_COMMIT
   } state_type;

   // Broadcast to every TLB cell
   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [STAMP_W-1:0] now;
      logic [TCNT_W-1:0]  count;
      logic [TIDX_W-1:0]  slot;
      logic               touch;  // stamp := now at slot
      logic               fill;   // page := page at slot
   } tlb_cmd_type;

   // Broadcast to every frame cell
   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [STAMP_W-1:0] now;
      logic [FCNT_W-1:0]  count;
      logic [FIDX_W-1:0]  slot;
      logic               wr;
      logic               hit_all; // refresh every matching frame
      logic               touch;   // stamp := now at slot
      logic               mark;    // dirty |= wr at slot
      logic               fill;    // page := page, dirty := wr at slot
   } frame_cmd_type;

endpackage

/* hw/rtl/tlb_page_table_replacement_sim_top.sv */
// Top level: TLB and page-frame replacement with round-robin or LRU policies.
//
// Input channel req_: one beat per access; req_tuser is the access kind
// (0 read, 1 write) and req_tdata the 32-bit virtual word address.
// Result channel rsp_: one beat per access carrying the hit/fault flags and
// the running fault, TLB-miss and write-back counters.
// Configuration: csr_we writes csr_wdata into the register at csr_addr
// (page size, TLB entries, frames, frame policy, TLB policy); write only
// while the block is idle.
// An access is worked through the divide, look-up and commit states. The wait in
// the divide state is set by the LRU minimum rippling through the 64-cell frame
// chain, one cell per cycle; the page-number divider runs inside that window.
// One access is in work at a time and the block returns to idle before taking
// the next, so it takes no new access until the last one has committed.
// The result sits in an output register; while the receiver stalls, the
// next access is still accepted and worked up to its commit, which waits
// until the held beat is taken.
// Reset (synchronous, active high) sets TLB entry i and frame i to page i,
// clears stamps, dirty bits, pointers and counters, and restores the
// configuration defaults; the block takes an access on the next cycle.
module tlb_page_table_replacement_sim_top
   import tpr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ADDR_W-1:0]    req_tdata,  // [31:0] address
   input  logic                 req_tuser,  // [0] op
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [0] tlb_hit, [1] page_hit, [2] page_fault, [3] disk_write,
   // [35:4] fault_count, [67:36] miss_count, [99:68] writeback_count, [103:100] zero
   output logic [103:0]         rsp_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [PSZ_W-1:0]     csr_wdata
);

   // configuration registers
   logic [PSZ_W-1:0]  psz_ff;
   logic [4:0]        tent_ff;
   logic [6:0]        frames_ff;
   logic              ppol_ff, tpol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         psz_ff    <= PSZ_W'(4096);
         tent_ff   <= 5'd16;
         frames_ff <= 7'd64;
         ppol_ff   <= 1'b0;
         tpol_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PAGE_SIZE:   psz_ff    <= csr_wdata;
            CSR_TLB_ENTRIES: tent_ff   <= csr_wdata[4:0];
            CSR_FRAMES:      frames_ff <= csr_wdata[6:0];
            CSR_PAGE_POLICY: ppol_ff   <= csr_wdata[0];
            CSR_TLB_POLICY:  tpol_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamped working values
   logic [PSZ_W-1:0]  psz;
   logic [TCNT_W-1:0] tcount;
   logic [FCNT_W-1:0] fcount;

   always_comb begin
      psz = (psz_ff < PSZ_W'(2)) ? PSZ_W'(2) : psz_ff;
      if (tent_ff == '0)                    tcount = TCNT_W'(1);
      else if (tent_ff > 5'(TLB_MAX))       tcount = TCNT_W'(TLB_MAX);
      else                                  tcount = TCNT_W'(tent_ff);
      if (frames_ff == '0)                  fcount = FCNT_W'(1);
      else if (frames_ff > 7'(FRAMES_MAX))  fcount = FCNT_W'(FRAMES_MAX);
      else                                  fcount = FCNT_W'(frames_ff);
   end

   // control and per-access registers
   state_type          state_ff, state_in;
   logic               wr_ff, wr_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic [STAMP_W-1:0] now_ff, now_in;
   logic [CNT_W-1:0]   faults_ff, faults_in, misses_ff, misses_in, wbs_ff, wbs_in;
   logic [TIDX_W-1:0]  tnext_ff, tnext_in;
   logic [FIDX_W-1:0]  fnext_ff, fnext_in;
   logic [TLB_MAX-1:0]    tmatch_ff, tmatch_in;
   logic [FRAMES_MAX-1:0] fmatch_ff, fmatch_in;
   logic [TIDX_W-1:0]  tlru_ff, tlru_in;
   logic [FIDX_W-1:0]  flru_ff, flru_in;
   logic               rvalid_ff, rvalid_in;
   logic [3:0]         rflags_ff, rflags_in;

   logic               div_start, div_done;
   logic [ADDR_W-1:0]  quotient;
   logic [PAGE_W-1:0]  page;

   tpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata),
      .divisor  (psz),
      .done     (div_done),
      .quotient (quotient)
   );

   // page size is at least two, so the top quotient bit is always zero
   assign page = quotient[PAGE_W-1:0];

   // cell chains
   tlb_cmd_type   tcmd;
   frame_cmd_type fcmd;
   logic [STAMP_W-1:0]    tms [TLB_MAX+1];
   logic [TIDX_W-1:0]     tmi [TLB_MAX+1];
   logic [STAMP_W-1:0]    fms [FRAMES_MAX+1];
   logic [FIDX_W-1:0]     fmi [FRAMES_MAX+1];
   logic [TLB_MAX-1:0]    tmatch;
   logic [FRAMES_MAX-1:0] fmatch, fdirty;

   assign tms[0] = '0;
   assign tmi[0] = '0;
   assign fms[0] = '0;
   assign fmi[0] = '0;

   for (genvar gi = 0; gi < TLB_MAX; gi++) begin : g_tlb
      tpr_tlb_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_idx      (TIDX_W'(gi)),
         .cmd           (tcmd),
         .min_stamp_in  (tms[gi]),
         .min_idx_in    (tmi[gi]),
         .min_stamp_out (tms[gi+1]),
         .min_idx_out   (tmi[gi+1]),
         .match         (tmatch[gi])
      );
   end

   for (genvar gj = 0; gj < FRAMES_MAX; gj++) begin : g_frame
      tpr_frame_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_idx      (FIDX_W'(gj)),
         .cmd           (fcmd),
         .min_stamp_in  (fms[gj]),
         .min_idx_in    (fmi[gj]),
         .min_stamp_out (fms[gj+1]),
         .min_idx_out   (fmi[gj+1]),
         .match         (fmatch[gj]),
         .dirty         (fdirty[gj])
      );
   end

   // lowest set bit of the match vectors
   function automatic logic [TIDX_W-1:0] first_t(input logic [TLB_MAX-1:0] v);
      logic [TIDX_W-1:0] r;
      r = '0;
      for (int k = TLB_MAX - 1; k >= 0; k--) if (v[k]) r = TIDX_W'(k);
      return r;
   endfunction

   function automatic logic [FIDX_W-1:0] first_f(input logic [FRAMES_MAX-1:0] v);
      logic [FIDX_W-1:0] r;
      r = '0;
      for (int k = FRAMES_MAX - 1; k >= 0; k--) if (v[k]) r = FIDX_W'(k);
      return r;
   endfunction

   logic              out_free, thit, phit, pfault, dwrite;
   logic [TIDX_W-1:0] tslot_rr, tslot;
   logic [FIDX_W-1:0] fslot_rr, victim;

   assign out_free   = !rvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign div_start  = req_tvalid && req_tready;

   always_comb begin
      state_in  = state_ff;
      wr_in     = wr_ff;
      scan_in   = scan_ff;
      now_in    = now_ff;
      faults_in = faults_ff;
      misses_in = misses_ff;
      wbs_in    = wbs_ff;
      tnext_in  = tnext_ff;
      fnext_in  = fnext_ff;
      tmatch_in = tmatch_ff;
      fmatch_in = fmatch_ff;
      tlru_in   = tlru_ff;
      flru_in   = flru_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rflags_in = rflags_ff;

      thit   = |tmatch_ff;
      phit   = !thit && (|fmatch_ff);
      pfault = !thit && !phit;

      // round-robin slots, a stale pointer acts as zero
      tslot_rr = ({1'b0, tnext_ff} < tcount) ? tnext_ff : '0;
      fslot_rr = ({1'b0, fnext_ff} < fcount) ? fnext_ff : '0;
      tslot    = tpol_ff ? tlru_ff : tslot_rr;
      victim   = ppol_ff ? flru_ff : fslot_rr;
      dwrite   = pfault && fdirty[victim];

      tcmd       = '0;
      tcmd.page  = page;
      tcmd.now   = now_ff;
      tcmd.count = tcount;
      fcmd       = '0;
      fcmd.page  = page;
      fcmd.now   = now_ff;
      fcmd.count = fcount;
      fcmd.wr    = wr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (div_start) begin
               wr_in    = req_tuser;
               scan_in  = '0;
               now_in   = now_ff + 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (scan_ff != SCAN_W'(SCAN_LEN)) scan_in = scan_ff + 1'b1;
            else if (div_done) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            tmatch_in = tmatch;
            fmatch_in = fmatch;
            tlru_in   = tmi[TLB_MAX];
            flru_in   = fmi[FRAMES_MAX];
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               if (thit) begin
                  tcmd.slot    = first_t(tmatch_ff);
                  tcmd.touch   = 1'b1;
                  fcmd.hit_all = 1'b1;
               end else begin
                  misses_in  = misses_ff + 1'b1;
                  tcmd.slot  = tslot;
                  tcmd.fill  = 1'b1;
                  tcmd.touch = tpol_ff;
                  if (!tpol_ff)
                     tnext_in = ({1'b0, tslot_rr} + 1'b1 >= tcount) ? '0 : tslot_rr + 1'b1;
                  if (phit) begin
                     fcmd.slot  = first_f(fmatch_ff);
                     fcmd.touch = 1'b1;
                     fcmd.mark  = 1'b1;
                  end else begin
                     faults_in  = faults_ff + 1'b1;
                     fcmd.slot  = victim;
                     fcmd.fill  = 1'b1;
                     fcmd.touch = ppol_ff;
                     if (!ppol_ff)
                        fnext_in = ({1'b0, fslot_rr} + 1'b1 >= fcount) ? '0 : fslot_rr + 1'b1;
                     if (dwrite) wbs_in = wbs_ff + 1'b1;
                  end
               end
               rvalid_in = 1'b1;
               rflags_in = {dwrite, pfault, phit, thit};
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      wr_ff     <= wr_in;
      tmatch_ff <= tmatch_in;
      fmatch_ff <= fmatch_in;
      tlru_ff   <= tlru_in;
      flru_ff   <= flru_in;
      rflags_ff <= rflags_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         scan_ff   <= '0;
         now_ff    <= '0;
         faults_ff <= '0;
         misses_ff <= '0;
         wbs_ff    <= '0;
         tnext_ff  <= '0;
         fnext_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         scan_ff   <= scan_in;
         now_ff    <= now_in;
         faults_ff <= faults_in;
         misses_ff <= misses_in;
         wbs_ff    <= wbs_in;
         tnext_ff  <= tnext_in;
         fnext_ff  <= fnext_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // counters only change at commit, which waits for the output slot
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {4'b0, wbs_ff, misses_ff, faults_ff, rflags_ff};

endmodule

/* hw/rtl/tpr_div.sv */
// Restoring divider, one quotient bit per cycle: page number = address / page size.
module tpr_div
   import tpr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] dividend,
   input  logic [PSZ_W-1:0]  divisor,
   output logic              done,
   output logic [ADDR_W-1:0] quotient
);

   localparam int STEP_W = $clog2(ADDR_W + 1);

   logic [ADDR_W-1:0] q_ff, q_in;
   logic [PSZ_W-1:0]  rem_ff, rem_in;
   logic [PSZ_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [PSZ_W:0]    trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, q_ff[ADDR_W-1]};
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = PSZ_W'(trial - {1'b0, div_ff});
            q_in   = {q_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = trial[PSZ_W-1:0];
            q_in   = {q_ff[ADDR_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(ADDR_W - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   assign done     = !busy_ff && !start;
   assign quotient = q_ff;

endmodule

/* hw/rtl/tpr_tlb_cell.sv */
// One TLB entry: page tag, LRU stamp and one link of the minimum-stamp chain.
module tpr_tlb_cell
   import tpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [TIDX_W-1:0]  cell_idx,
   input  tlb_cmd_type        cmd,
   input  logic [STAMP_W-1:0] min_stamp_in,
   input  logic [TIDX_W-1:0]  min_idx_in,
   output logic [STAMP_W-1:0] min_stamp_out,
   output logic [TIDX_W-1:0]  min_idx_out,
   output logic               match
);

   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [STAMP_W-1:0] mstamp_ff, mstamp_in;
   logic [TIDX_W-1:0]  midx_ff, midx_in;
   logic               in_use, sel, take_own;

   assign in_use = {1'b0, cell_idx} < cmd.count;
   assign sel    = cmd.slot == cell_idx;
   assign match  = in_use && (page_ff == cmd.page);

   always_comb begin
      page_in  = page_ff;
      stamp_in = stamp_ff;
      if (sel && cmd.fill)  page_in  = cmd.page;
      if (sel && cmd.touch) stamp_in = cmd.now;
   end

   // running minimum, ties kept by the lower index
   assign take_own  = (cell_idx == '0) || (in_use && stamp_ff < min_stamp_in);
   assign mstamp_in = take_own ? stamp_ff : min_stamp_in;
   assign midx_in   = take_own ? cell_idx : min_idx_in;

   always_ff @(posedge clock) begin
      mstamp_ff <= mstamp_in;
      midx_ff   <= midx_in;
      if (reset) begin
         page_ff  <= PAGE_W'(cell_idx);
         stamp_ff <= '0;
      end else begin
         page_ff  <= page_in;
         stamp_ff <= stamp_in;
      end
   end

   assign min_stamp_out = mstamp_ff;
   assign min_idx_out   = midx_ff;

endmodule

/* hw/rtl/tpr_frame_cell.sv */
// One page frame: resident page, LRU stamp, dirty bit and a link of the minimum chain.
module tpr_frame_cell
   import tpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [FIDX_W-1:0]  cell_idx,
   input  frame_cmd_type      cmd,
   input  logic [STAMP_W-1:0] min_stamp_in,
   input  logic [FIDX_W-1:0]  min_idx_in,
   output logic [STAMP_W-1:0] min_stamp_out,
   output logic [FIDX_W-1:0]  min_idx_out,
   output logic               match,
   output logic               dirty
);

   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic               dirty_ff, dirty_in;
   logic [STAMP_W-1:0] mstamp_ff, mstamp_in;
   logic [FIDX_W-1:0]  midx_ff, midx_in;
   logic               in_use, sel, take_own;

   assign in_use = {1'b0, cell_idx} < cmd.count;
   assign sel    = cmd.slot == cell_idx;
   assign match  = in_use && (page_ff == cmd.page);

   always_comb begin
      page_in  = page_ff;
      stamp_in = stamp_ff;
      dirty_in = dirty_ff;
      if ((cmd.hit_all && match) || (cmd.touch && sel)) stamp_in = cmd.now;
      if (((cmd.hit_all && match) || (cmd.mark && sel)) && cmd.wr) dirty_in = 1'b1;
      if (cmd.fill && sel) begin
         page_in  = cmd.page;
         dirty_in = cmd.wr;
      end
   end

   assign take_own  = (cell_idx == '0) || (in_use && stamp_ff < min_stamp_in);
   assign mstamp_in = take_own ? stamp_ff : min_stamp_in;
   assign midx_in   = take_own ? cell_idx : min_idx_in;

   always_ff @(posedge clock) begin
      mstamp_ff <= mstamp_in;
      midx_ff   <= midx_in;
      if (reset) begin
         page_ff  <= PAGE_W'(cell_idx);
         stamp_ff <= '0;
         dirty_ff <= 1'b0;
      end else begin
         page_ff  <= page_in;
         stamp_ff <= stamp_in;
         dirty_ff <= dirty_in;
      end
   end

   assign min_stamp_out = mstamp_ff;
   assign min_idx_out   = midx_ff;
   assign dirty         = dirty_ff;

endmodule

/* hw/rtl/tpr_checker.sv */
// Port-level checker for the TLB replacement block, bound to the top level.
module tpr_checker
   import tpr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // no result right out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // exactly one outcome per access
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(rsp_tdata[2:0]))
      else $error("outcome flags not one-hot");

   // write-back only on a fault
   a_wb_on_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2])
      else $error("disk write without page fault");

   // one access in work at a time
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a second access while busy");

endmodule

bind tlb_page_table_replacement_sim_top tpr_checker u_tpr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* bench/tb_tlb_page_table_replacement_sim_top.sv */
// Self-checking bench for the TLB and page-frame replacement block.
`timescale 1ns / 100ps

module tb_tlb_page_table_replacement_sim_top;
   import tpr_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ADDR_W-1:0]    req_tdata = '0;   // [31:0] address
   logic                 req_tuser = 1'b0; // [0] op
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // [0] tlb_hit, [1] page_hit, [2] page_fault, [3] disk_write,
   // [35:4] fault_count, [67:36] miss_count, [99:68] writeback_count
   logic [103:0]         rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = '0;
   logic [PSZ_W-1:0]     csr_wdata = '0;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic              op;
      logic [ADDR_W-1:0] addr;
   } access_type;

   typedef struct packed {
      logic [CNT_W-1:0] writebacks;
      logic [CNT_W-1:0] misses;
      logic [CNT_W-1:0] faults;
      logic             disk_write;
      logic             page_fault;
      logic             page_hit;
      logic             tlb_hit;
   } xlate_type;

   tlb_page_table_replacement_sim_top uut (.*);

   always #1 clock = ~clock;

   // translation model state
   logic [PSZ_W-1:0]   m_psz;
   logic [4:0]         m_tlb_cnt;
   logic [6:0]         m_frm_cnt;
   logic               m_pg_lru, m_tlb_lru;
   logic [PAGE_W:0]    tlb_pg [TLB_MAX];
   logic [STAMP_W-1:0] tlb_st [TLB_MAX];
   logic [PAGE_W:0]    frm_pg [FRAMES_MAX];
   logic [STAMP_W-1:0] frm_st [FRAMES_MAX];
   logic               frm_dirty [FRAMES_MAX];
   int unsigned        tlb_ptr, frm_ptr;
   logic [31:0]        tick, n_fault, n_miss, n_wb;

   access_type  pending_q [$];
   xlate_type   expected_q [$];
   int          errors = 0;
   int          beats_out = 0;
   int          send_idle_pct = 0, recv_stall_pct = 0;
   bit          stim_done = 0;

   function automatic void model_reset();
      m_psz = PSZ_W'(4096); m_tlb_cnt = 5'd16; m_frm_cnt = 7'd64;
      m_pg_lru = 1'b0; m_tlb_lru = 1'b0;
      for (int i = 0; i < TLB_MAX; i++) begin
         tlb_pg[i] = i; tlb_st[i] = '0;
      end
      for (int i = 0; i < FRAMES_MAX; i++) begin
         frm_pg[i] = i; frm_st[i] = '0; frm_dirty[i] = 1'b0;
      end
      tlb_ptr = 0; frm_ptr = 0; tick = '0; n_fault = '0; n_miss = '0; n_wb = '0;
   endfunction

   function automatic int unsigned clamp(int unsigned v, int unsigned mx);
      return (v < 1) ? 1 : (v > mx) ? mx : v;
   endfunction

   function automatic int unsigned rr_next(ref int unsigned ptr, input int unsigned cnt);
      int unsigned slot;
      slot = (ptr < cnt) ? ptr : 0;
      ptr = (slot + 1 >= cnt) ? 0 : slot + 1;
      return slot;
   endfunction

   function automatic void tlb_fill(logic [PAGE_W:0] pg, int unsigned tc);
      int unsigned slot;
      if (m_tlb_lru) begin
         slot = 0;
         for (int i = 1; i < tc; i++) if (tlb_st[i] < tlb_st[slot]) slot = i;
         tlb_st[slot] = tick;
      end else begin
         slot = rr_next(tlb_ptr, tc);
      end
      tlb_pg[slot] = pg;
   endfunction

   function automatic xlate_type translate(access_type a);
      xlate_type r;
      int unsigned psz, tc, fc, victim;
      logic [PAGE_W:0] pg;
      r = '0;
      psz = (m_psz < 2) ? 2 : m_psz;
      tc = clamp(m_tlb_cnt, TLB_MAX);
      fc = clamp(m_frm_cnt, FRAMES_MAX);
      tick++;
      pg = a.addr / psz;
      for (int i = 0; i < tc; i++) begin
         if (tlb_pg[i] == pg) begin
            r.tlb_hit = 1'b1;
            tlb_st[i] = tick;
            for (int j = 0; j < fc; j++) begin
               if (frm_pg[j] == pg) begin
                  frm_st[j] = tick;
                  if (a.op) frm_dirty[j] = 1'b1;
               end
            end
            break;
         end
      end
      if (!r.tlb_hit) begin
         n_miss++;
         for (int i = 0; i < fc; i++) begin
            if (frm_pg[i] == pg) begin
               r.page_hit = 1'b1;
               frm_st[i] = tick;
               if (a.op) frm_dirty[i] = 1'b1;
               tlb_fill(pg, tc);
               break;
            end
         end
         if (!r.page_hit) begin
            r.page_fault = 1'b1;
            n_fault++;
            if (m_pg_lru) begin
               victim = 0;
               for (int i = 1; i < fc; i++) if (frm_st[i] < frm_st[victim]) victim = i;
               frm_st[victim] = tick;
            end else begin
               victim = rr_next(frm_ptr, fc);
            end
            if (frm_dirty[victim]) begin
               r.disk_write = 1'b1;
               n_wb++;
            end
            tlb_fill(pg, tc);
            frm_pg[victim] = pg;
            frm_dirty[victim] = a.op;
         end
      end
      r.faults = n_fault; r.misses = n_miss; r.writebacks = n_wb;
      return r;
   endfunction

   // driver: feeds pending accesses, predicts on acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) expected_q.push_back(translate({req_tuser, req_tdata}));
         if ((!req_tvalid || req_tready) ) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               access_type a;
               a = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= a.op;
               req_tdata  <= a.addr;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares result beats against predictions
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            beats_out++;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_tdata);
               errors++;
            end else begin
               xlate_type e, g;
               e = expected_q.pop_front();
               g = rsp_tdata[99:0];
               if (e.tlb_hit !== g.tlb_hit)
                  $display("%0t: tlb_hit exp %0d got %0d", $time, e.tlb_hit, g.tlb_hit);
               if (e.page_hit !== g.page_hit)
                  $display("%0t: page_hit exp %0d got %0d", $time, e.page_hit, g.page_hit);
               if (e.page_fault !== g.page_fault)
                  $display("%0t: page_fault exp %0d got %0d", $time, e.page_fault,
                           g.page_fault);
               if (e.disk_write !== g.disk_write)
                  $display("%0t: disk_write exp %0d got %0d", $time, e.disk_write,
                           g.disk_write);
               if (e.faults !== g.faults)
                  $display("%0t: fault_count exp %0d got %0d", $time, e.faults, g.faults);
               if (e.misses !== g.misses)
                  $display("%0t: miss_count exp %0d got %0d", $time, e.misses, g.misses);
               if (e.writebacks !== g.writebacks)
                  $display("%0t: writeback_count exp %0d got %0d", $time, e.writebacks,
                           g.writebacks);
               if (e !== g) errors++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic csr_write(csr_idx_type idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= PSZ_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      unique case (idx)
         CSR_PAGE_SIZE:   m_psz = PSZ_W'(val);
         CSR_TLB_ENTRIES: m_tlb_cnt = 5'(val);
         CSR_FRAMES:      m_frm_cnt = 7'(val);
         CSR_PAGE_POLICY: m_pg_lru = val[0];
         CSR_TLB_POLICY:  m_tlb_lru = val[0];
         default: ;
      endcase
   endtask

   // let the block drain fully before touching configuration
   task automatic drain();
      while (pending_q.size() != 0 || req_tvalid || expected_q.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // random accesses: mostly a small working set of pages, some wild addresses
   task automatic queue_random(int n, int unsigned psz, int unsigned span);
      int unsigned p;
      for (int i = 0; i < n; i++) begin
         access_type a;
         a.op = 1'($urandom_range(1));
         if ($urandom_range(9) == 0) begin
            a.addr = $urandom;
         end else begin
            p = $urandom_range(span);
            a.addr = p * psz + $urandom_range(psz - 1);
         end
         pending_q.push_back(a);
      end
   endtask

   typedef struct {
      int unsigned psz, tlb, frm, plru, tlru;
   } setting_type;

   initial begin
      setting_type cfg [8];
      int per;
      model_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme addresses, both ops, duplicate pages from reset map
      pending_q.push_back('{OP_READ, 32'h0000_0000});
      pending_q.push_back('{OP_WRITE, 32'h0000_0FFF});
      pending_q.push_back('{OP_READ, 32'hFFFF_FFFF});
      pending_q.push_back('{OP_WRITE, 32'hFFFF_FFFF});
      pending_q.push_back('{OP_WRITE, 32'h0001_0000});
      pending_q.push_back('{OP_READ, 32'hAAAA_AAAA});
      pending_q.push_back('{OP_WRITE, 32'h5555_5555});
      pending_q.push_back('{OP_READ, 32'h0000_1000});
      drain();
      // small page below two, zero counts, pointer beyond count
      csr_write(CSR_PAGE_SIZE, 0);
      csr_write(CSR_TLB_ENTRIES, 0);
      csr_write(CSR_FRAMES, 0);
      pending_q.push_back('{OP_WRITE, 32'h0000_0007});
      pending_q.push_back('{OP_WRITE, 32'h0000_0009});
      pending_q.push_back('{OP_READ, 32'h0000_0006});
      pending_q.push_back('{OP_READ, 32'h8000_0001});
      drain();
      csr_write(CSR_PAGE_SIZE, 1);
      csr_write(CSR_TLB_ENTRIES, 31);
      csr_write(CSR_FRAMES, 127);
      csr_write(CSR_PAGE_POLICY, 1);
      csr_write(CSR_TLB_POLICY, 1);
      pending_q.push_back('{OP_WRITE, 32'h0000_0001});
      pending_q.push_back('{OP_READ, 32'hFFFF_FFFE});
      pending_q.push_back('{OP_WRITE, 32'h1234_5678});
      drain();

      cfg[0] = '{4096, 16, 64, 0, 0};
      cfg[1] = '{2, 4, 8, 1, 1};
      cfg[2] = '{65536, 1, 1, 0, 1};
      cfg[3] = '{16, 8, 4, 1, 0};
      cfg[4] = '{130000, 16, 64, 1, 1};
      cfg[5] = '{2, 16, 2, 0, 0};
      cfg[6] = '{256, 3, 5, 1, 1};
      cfg[7] = '{1024, 12, 20, 0, 1};
      per = 240;
      for (int k = 0; k < 8; k++) begin
         int unsigned psz;
         csr_write(CSR_PAGE_SIZE, cfg[k].psz);
         csr_write(CSR_TLB_ENTRIES, cfg[k].tlb);
         csr_write(CSR_FRAMES, cfg[k].frm);
         csr_write(CSR_PAGE_POLICY, cfg[k].plru);
         csr_write(CSR_TLB_POLICY, cfg[k].tlru);
         psz = (m_psz < 2) ? 2 : m_psz;
         case (k % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         queue_random(per, psz, clamp(cfg[k].frm, FRAMES_MAX) + 3);
         drain();
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      $display("Covered %0d accesses over eight settings of page size, counts and",
               beats_out);
      $display("policies, with sender gaps and receiver stalls.");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/tpr_pkg.sv
hw/rtl/tpr_div.sv
hw/rtl/tpr_tlb_cell.sv
hw/rtl/tpr_frame_cell.sv
hw/rtl/tlb_page_table_replacement_sim_top.sv
hw/rtl/tpr_checker.sv
bench/tb_tlb_page_table_replacement_sim_top.sv
